// ----- rtl/svpd_pkg.sv -----
`default_nettype none

package svpd_pkg;

    localparam int TURN_BITS      = 24;
    localparam int ANGLE_BITS_DEF = 16;
    localparam int CORDIC_N       = 24;
    localparam int SQ_W           = 32;
    localparam int SQRT_N         = SQ_W;
    localparam int SQ_REM_W       = SQ_W + 2;
    localparam int DIV_W          = 32;
    localparam int DIV_N          = DIV_W;
    localparam int SUP_W          = 16;
    localparam int CW             = 36;
    localparam int ZW             = 26;
    localparam int SW             = CW - 14;
    localparam int MW             = DIV_W + 1;
    localparam int DW             = 40;
    localparam int PCT_W          = 7;
    localparam int PER_W          = 10;

    localparam logic [ZW-1:0] HALF_TURN    = ZW'(8388608);
    localparam logic [ZW-1:0] QUARTER_TURN = ZW'(4194304);
    localparam logic [ZW-1:0] SIXTH_TURN   = ZW'(2796203);
    localparam logic [CW-1:0] SQRT3_GAIN   = CW'(1129354069);

    // x/6 for x below 2^25 as (x * ceil(2^26/6)) >> 26
    localparam logic [23:0] PHI_RECIP = 24'd11184811;
    localparam int          PHI_SHIFT = 26;
    // x/100 for 16-bit x as (x * ceil(2^23/100)) >> 23
    localparam logic [16:0] PER_RECIP = 17'd83887;
    localparam int          PER_SHIFT = 23;

    localparam logic [15:0] SUPPLY_RST = 16'd3072;
    localparam logic [15:0] PERIOD_RST = 16'd4200;

    typedef enum logic {
        REG_SUPPLY = 1'b0,
        REG_PERIOD = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0] {
        SEC_1 = 3'd1,
        SEC_2 = 3'd2,
        SEC_3 = 3'd3,
        SEC_4 = 3'd4,
        SEC_5 = 3'd5,
        SEC_6 = 3'd6
    } sector_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
    } cordic_t;

    typedef struct packed {
        logic [SQ_W-1:0]     rad;
        logic [SQ_REM_W-1:0] rem;
        logic [SQ_W-1:0]     root;
    } sqrt_t;

    typedef struct packed {
        logic [DIV_W-1:0] num;
        logic [SUP_W-1:0] rem;
        logic [DIV_W-1:0] quo;
    } div_t;

    // arctan(2^-i) in 2^-24 turn
    function automatic logic [21:0] atan_step(input int i);
        logic [21:0] v;
        case (i)
            0:       v = 22'd2097152;
            1:       v = 22'd1238021;
            2:       v = 22'd654136;
            3:       v = 22'd332050;
            4:       v = 22'd166669;
            5:       v = 22'd83416;
            6:       v = 22'd41718;
            7:       v = 22'd20860;
            8:       v = 22'd10430;
            9:       v = 22'd5215;
            10:      v = 22'd2608;
            11:      v = 22'd1304;
            12:      v = 22'd652;
            13:      v = 22'd326;
            14:      v = 22'd163;
            15:      v = 22'd81;
            16:      v = 22'd41;
            17:      v = 22'd20;
            18:      v = 22'd10;
            19:      v = 22'd5;
            20:      v = 22'd3;
            21:      v = 22'd1;
            22:      v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

    // whole percent of a Q16 duty, clamped to 0..100
    function automatic logic [PCT_W-1:0] duty_pct(input logic signed [DW-1:0] duty);
        logic [22:0] prod;
        logic [PCT_W-1:0] p;
        prod = 23'(duty[15:0]) * 23'd100;
        if (duty < 0) p = '0;
        else if (duty >= DW'(65536)) p = PCT_W'(100);
        else p = prod[22:16];
        return p;
    endfunction

    // compare = step*pct - 1, held at zero
    function automatic logic [15:0] pct_compare(input logic [PER_W-1:0] step,
                                                input logic [PCT_W-1:0] pct);
        logic [16:0] prod;
        logic [15:0] c;
        prod = 17'(step) * 17'(pct);
        if (prod == '0) c = '0;
        else c = 16'(prod - 17'd1);
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/svpd_cmd_if.sv -----
`default_nettype none

interface svpd_cmd_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] volt_q;
    logic signed [15:0] volt_d;
    logic        [15:0] elec_angle;

    modport source (output valid, output volt_q, output volt_d, output elec_angle,
                    input ready);
    modport sink (input valid, input volt_q, input volt_d, input elec_angle,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/svpd_duty_if.sv -----
`default_nettype none

interface svpd_duty_if;
    logic        valid;
    logic        ready;
    logic [15:0] compare_a;
    logic [15:0] compare_b;
    logic [15:0] compare_c;
    logic [2:0]  sector;

    modport source (output valid, output compare_a, output compare_b, output compare_c,
                    output sector, input ready);
    modport sink (input valid, input compare_a, input compare_b, input compare_c,
                  input sector, output ready);
endinterface

`default_nettype wire

// ----- rtl/svpd_delay.sv -----
`default_nettype none

module svpd_delay #(
    parameter int W     = 1,
    parameter int DEPTH = 1
) (
    input  wire logic         clk,
    input  wire logic         en,
    input  wire logic [W-1:0] din,
    output logic      [W-1:0] dout
);

    logic [W-1:0] tap_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign dout = tap_reg[DEPTH-1];

endmodule

`default_nettype wire

// ----- rtl/svpd_sqrt_cell.sv -----
`default_nettype none

// One root bit: bring down two radicand bits, try the next root digit.
module svpd_sqrt_cell (
    input  wire logic            clk,
    input  wire logic            en,
    input  wire svpd_pkg::sqrt_t din,
    output svpd_pkg::sqrt_t      dout
);

    svpd_pkg::sqrt_t data_reg, data_next;
    logic [svpd_pkg::SQ_REM_W+1:0] part;
    logic [svpd_pkg::SQ_REM_W+1:0] trial;

    always_comb
    begin
        part  = {din.rem, din.rad[svpd_pkg::SQ_W-1 -: 2]};
        trial = {2'b00, din.root, 2'b01};
        data_next.rad = {din.rad[svpd_pkg::SQ_W-3:0], 2'b00};
        if (part >= trial)
        begin
            data_next.rem  = svpd_pkg::SQ_REM_W'(part - trial);
            data_next.root = {din.root[svpd_pkg::SQ_W-2:0], 1'b1};
        end
        else
        begin
            data_next.rem  = svpd_pkg::SQ_REM_W'(part);
            data_next.root = {din.root[svpd_pkg::SQ_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign dout = data_reg;

endmodule

`default_nettype wire

// ----- rtl/svpd_div_cell.sv -----
`default_nettype none

// One quotient bit of a restoring divide by the supply voltage.
module svpd_div_cell (
    input  wire logic                         clk,
    input  wire logic                         en,
    input  wire logic [svpd_pkg::SUP_W-1:0]   divisor,
    input  wire svpd_pkg::div_t               din,
    output svpd_pkg::div_t                    dout
);

    svpd_pkg::div_t data_reg, data_next;
    logic [svpd_pkg::SUP_W:0] part;
    logic                     fits;

    always_comb
    begin
        part = {din.rem, din.num[svpd_pkg::DIV_W-1]};
        fits = part >= {1'b0, divisor};
        data_next.num = {din.num[svpd_pkg::DIV_W-2:0], 1'b0};
        data_next.rem = fits ? svpd_pkg::SUP_W'(part - {1'b0, divisor})
                             : svpd_pkg::SUP_W'(part);
        data_next.quo = {din.quo[svpd_pkg::DIV_W-2:0], fits};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign dout = data_reg;

endmodule

`default_nettype wire

// ----- rtl/svpd_cordic_cell.sv -----
`default_nettype none

// One CORDIC micro-rotation; vectoring drives y to zero, rotation drives z to zero.
module svpd_cordic_cell #(
    parameter int STEP   = 0,
    parameter bit VECTOR = 1'b1
) (
    input  wire logic              clk,
    input  wire logic              en,
    input  wire svpd_pkg::cordic_t din,
    output svpd_pkg::cordic_t      dout
);

    svpd_pkg::cordic_t data_reg, data_next;
    logic signed [svpd_pkg::CW-1:0] dx;
    logic signed [svpd_pkg::CW-1:0] dy;
    logic signed [svpd_pkg::ZW-1:0] da;
    logic                           neg;

    always_comb
    begin
        dx  = din.x >>> STEP;
        dy  = din.y >>> STEP;
        da  = $signed(svpd_pkg::ZW'(svpd_pkg::atan_step(STEP)));
        neg = VECTOR ? !(din.y > 0) : (din.z >= 0);
        data_next.x = neg ? din.x - dy : din.x + dy;
        data_next.y = neg ? din.y + dx : din.y - dx;
        data_next.z = neg ? din.z - da : din.z + da;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign dout = data_reg;

endmodule

`default_nettype wire

// ----- rtl/space_vector_pwm_duty.sv -----
`default_nettype none

// Space vector PWM duty pipeline. Each item carries a q/d voltage command
// (signed Q8.8) and an electrical angle (65536 = one turn); each result gives
// the three timer compare values and the 60 degree sector. The block takes one
// item per clock while the output is taken. The magnitude path is the longest:
// a squaring stage and a summing stage, a 32-cell square root row and a
// 32-cell divider row form the magnitude ratio, followed by the lead/trail
// multiply, the duty, the percent and the compare stages. The angle (atan2 row
// of 24 cells, sector split, two 24-cell sine rows) runs beside it and is
// delayed to meet it. When the output register holds a result nobody takes,
// the whole row holds and the command side stops taking items. Registers:
// supply_voltage at byte address 0, period_count at 4; write them only while
// no item is in flight.

module space_vector_pwm_duty #(
    parameter int ANGLE_BITS = svpd_pkg::ANGLE_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    svpd_cmd_if.sink         cmd,
    svpd_duty_if.source      duty
);

    // stage numbers (register index after the input register)
    localparam int ST_SQ    = 2;
    localparam int ST_ROOT  = ST_SQ + svpd_pkg::SQRT_N;
    localparam int ST_QUO   = ST_ROOT + svpd_pkg::DIV_N;
    localparam int ST_M     = ST_QUO + 1;
    localparam int ST_Z     = svpd_pkg::CORDIC_N;
    localparam int ST_FRAC  = ST_Z + 1;
    localparam int ST_PHI   = ST_Z + 3;
    localparam int ST_SIN   = ST_PHI + svpd_pkg::CORDIC_N;
    localparam int ST_LT    = ST_M + 1;
    localparam int ST_DUTY  = ST_LT + 1;
    localparam int ST_PCT   = ST_DUTY + 1;
    localparam int FRAC_PAD = svpd_pkg::TURN_BITS - ANGLE_BITS;

    // ---------------- configuration port ----------------
    logic [15:0] supply_reg;
    logic [15:0] period_reg;
    logic        cfg_wr;
    svpd_pkg::reg_idx_t cfg_idx;

    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = svpd_pkg::reg_idx_t'(paddr[2]);
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            supply_reg <= svpd_pkg::SUPPLY_RST;
            period_reg <= svpd_pkg::PERIOD_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                svpd_pkg::REG_SUPPLY: supply_reg <= pwdata[15:0];
                svpd_pkg::REG_PERIOD: period_reg <= pwdata[15:0];
                default:              supply_reg <= supply_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            svpd_pkg::REG_SUPPLY: prdata = {16'd0, supply_reg};
            svpd_pkg::REG_PERIOD: prdata = {16'd0, period_reg};
            default:              prdata = '0;
        endcase
    end

    // zero supply divides by one
    logic [svpd_pkg::SUP_W-1:0] divisor;
    assign divisor = (supply_reg == '0) ? svpd_pkg::SUP_W'(1) : supply_reg;

    // counts per percent, refreshed every cycle from the period register
    logic [32:0]                 step_prod;
    logic [svpd_pkg::PER_W-1:0]  step_reg;
    assign step_prod = 33'(period_reg) * 33'(svpd_pkg::PER_RECIP);

    always_ff @(posedge clk)
    begin
        step_reg <= step_prod[svpd_pkg::PER_SHIFT +: svpd_pkg::PER_W];
    end

    // ---------------- flow control ----------------
    logic              adv;
    logic [ST_PCT:0]   vld_reg;
    logic              out_valid_reg;

    // advance the whole row unless a finished result is stuck at the output
    assign adv       = !out_valid_reg || duty.ready;
    assign cmd.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg       <= {vld_reg[ST_PCT-1:0], cmd.valid};
            out_valid_reg <= vld_reg[ST_PCT];
        end
    end

    // ---------------- stage 0: input register ----------------
    logic signed [15:0] q_reg;
    logic signed [15:0] d_reg;
    logic        [15:0] ang_reg;
    logic               dz;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q_reg   <= cmd.volt_q;
            d_reg   <= cmd.volt_d;
            ang_reg <= cmd.elec_angle;
        end
    end

    assign dz = (d_reg == '0);

    // ---------------- magnitude: d^2 + q^2 ----------------
    logic [31:0] dd_reg;
    logic [31:0] qq_reg;
    logic [31:0] sq_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dd_reg <= 32'(d_reg * d_reg);
            qq_reg <= 32'(q_reg * q_reg);
            sq_reg <= dd_reg + qq_reg;
        end
    end

    // square root of sq * 2^32; the low radicand half is all zeros
    svpd_pkg::sqrt_t sq_chain [svpd_pkg::SQRT_N+1];
    assign sq_chain[0] = '{rad: sq_reg, rem: '0, root: '0};

    for (genvar k = 0; k < svpd_pkg::SQRT_N; k++)
    begin : g_sqrt
        svpd_sqrt_cell u_cell (
            .clk  (clk),
            .en   (adv),
            .din  (sq_chain[k]),
            .dout (sq_chain[k+1])
        );
    end

    // the pure q path needs its flag and q beside the root
    logic               dz_root;
    logic signed [15:0] q_root;

    svpd_delay #(.W(17), .DEPTH(ST_ROOT)) u_dly_root (
        .clk  (clk),
        .en   (adv),
        .din  ({dz, q_reg}),
        .dout ({dz_root, q_root})
    );

    logic [16:0]                q_abs;
    logic [svpd_pkg::DIV_W-1:0] dividend;
    logic                       neg_root;

    assign q_abs    = q_root[15] ? 17'(-(18'(q_root))) : 17'(q_root);
    assign dividend = dz_root ? (svpd_pkg::DIV_W'(q_abs) << 16)
                              : sq_chain[svpd_pkg::SQRT_N].root;
    assign neg_root = dz_root && q_root[15];

    svpd_pkg::div_t dv_chain [svpd_pkg::DIV_N+1];
    assign dv_chain[0] = '{num: dividend, rem: '0, quo: '0};

    for (genvar k = 0; k < svpd_pkg::DIV_N; k++)
    begin : g_div
        svpd_div_cell u_cell (
            .clk     (clk),
            .en      (adv),
            .divisor (divisor),
            .din     (dv_chain[k]),
            .dout    (dv_chain[k+1])
        );
    end

    logic neg_quo;

    svpd_delay #(.W(1), .DEPTH(svpd_pkg::DIV_N)) u_dly_neg (
        .clk  (clk),
        .en   (adv),
        .din  (neg_root),
        .dout (neg_quo)
    );

    // signed Q16 magnitude ratio
    logic signed [svpd_pkg::MW-1:0] m_reg;
    logic signed [svpd_pkg::MW-1:0] quo_s;

    assign quo_s = $signed({1'b0, dv_chain[svpd_pkg::DIV_N].quo});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_reg <= neg_quo ? -quo_s : quo_s;
        end
    end

    // ---------------- angle: atan2(q, d) ----------------
    logic signed [svpd_pkg::CW-1:0] x0;
    logic signed [svpd_pkg::CW-1:0] y0;
    svpd_pkg::cordic_t vc_chain [svpd_pkg::CORDIC_N+1];

    assign x0 = svpd_pkg::CW'(d_reg) <<< 16;
    assign y0 = svpd_pkg::CW'(q_reg) <<< 16;

    // turn a vector in the left half plane by a half turn first
    assign vc_chain[0] = d_reg[15] ? '{x: -x0, y: -y0, z: svpd_pkg::HALF_TURN}
                                   : '{x: x0, y: y0, z: '0};

    for (genvar k = 0; k < svpd_pkg::CORDIC_N; k++)
    begin : g_vec
        svpd_cordic_cell #(.STEP(k), .VECTOR(1'b1)) u_cell (
            .clk  (clk),
            .en   (adv),
            .din  (vc_chain[k]),
            .dout (vc_chain[k+1])
        );
    end

    logic        dz_z;
    logic [15:0] ang_z;

    svpd_delay #(.W(17), .DEPTH(ST_Z)) u_dly_ang (
        .clk  (clk),
        .en   (adv),
        .din  ({dz, ang_reg}),
        .dout ({dz_z, ang_z})
    );

    // sector and position inside it
    logic [svpd_pkg::ZW-1:0]  adv_ang;
    logic [svpd_pkg::ZW-1:0]  ang_sum;
    logic [ANGLE_BITS-1:0]    theta;
    logic [ANGLE_BITS+2:0]    six;
    logic [2:0]               sec_reg;
    logic [ANGLE_BITS-1:0]    frac_reg;

    assign adv_ang = dz_z ? svpd_pkg::QUARTER_TURN : vc_chain[svpd_pkg::CORDIC_N].z;
    assign ang_sum = svpd_pkg::ZW'({ang_z, 8'd0}) + adv_ang;
    assign theta   = ang_sum[svpd_pkg::TURN_BITS-1 -: ANGLE_BITS];
    assign six     = (ANGLE_BITS+3)'(theta) * (ANGLE_BITS+3)'(6);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sec_reg  <= six[ANGLE_BITS +: 3] + 3'd1;
            frac_reg <= six[ANGLE_BITS-1:0];
        end
    end

    // phi = frac scaled to 2^-24 turn, divided by six
    logic [47:0]               phi_prod_reg;
    logic [21:0]               phi;
    logic signed [svpd_pkg::ZW-1:0] lead_ang_reg;
    logic signed [svpd_pkg::ZW-1:0] trail_ang_reg;

    assign phi = phi_prod_reg[svpd_pkg::PHI_SHIFT +: 22];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            phi_prod_reg  <= 48'(24'(frac_reg) << FRAC_PAD) * 48'(svpd_pkg::PHI_RECIP);
            lead_ang_reg  <= $signed(svpd_pkg::SIXTH_TURN - svpd_pkg::ZW'(phi));
            trail_ang_reg <= $signed(svpd_pkg::ZW'(phi));
        end
    end

    // sqrt3 * sin for both sides of the sector
    svpd_pkg::cordic_t rl_chain [svpd_pkg::CORDIC_N+1];
    svpd_pkg::cordic_t rt_chain [svpd_pkg::CORDIC_N+1];

    assign rl_chain[0] = '{x: svpd_pkg::SQRT3_GAIN, y: '0, z: lead_ang_reg};
    assign rt_chain[0] = '{x: svpd_pkg::SQRT3_GAIN, y: '0, z: trail_ang_reg};

    for (genvar k = 0; k < svpd_pkg::CORDIC_N; k++)
    begin : g_rot
        svpd_cordic_cell #(.STEP(k), .VECTOR(1'b0)) u_lead (
            .clk  (clk),
            .en   (adv),
            .din  (rl_chain[k]),
            .dout (rl_chain[k+1])
        );
        svpd_cordic_cell #(.STEP(k), .VECTOR(1'b0)) u_trail (
            .clk  (clk),
            .en   (adv),
            .din  (rt_chain[k]),
            .dout (rt_chain[k+1])
        );
    end

    // drop Q30 to Q16 and hold until the magnitude arrives
    logic signed [svpd_pkg::SW-1:0] s_lead;
    logic signed [svpd_pkg::SW-1:0] s_trail;
    logic [svpd_pkg::SW-1:0]        s_lead_d;
    logic [svpd_pkg::SW-1:0]        s_trail_d;

    assign s_lead  = svpd_pkg::SW'(rl_chain[svpd_pkg::CORDIC_N].y >>> 14);
    assign s_trail = svpd_pkg::SW'(rt_chain[svpd_pkg::CORDIC_N].y >>> 14);

    svpd_delay #(.W(2*svpd_pkg::SW), .DEPTH(ST_M - ST_SIN)) u_dly_sin (
        .clk  (clk),
        .en   (adv),
        .din  ({s_lead, s_trail}),
        .dout ({s_lead_d, s_trail_d})
    );

    logic [2:0] sec_lt;

    svpd_delay #(.W(3), .DEPTH(ST_LT - ST_FRAC)) u_dly_sec (
        .clk  (clk),
        .en   (adv),
        .din  (sec_reg),
        .dout (sec_lt)
    );

    // ---------------- lead / trail times ----------------
    localparam int PW = svpd_pkg::SW + svpd_pkg::MW;

    logic signed [PW-1:0]           lead_prod;
    logic signed [PW-1:0]           trail_prod;
    logic signed [svpd_pkg::DW-1:0] lead_reg;
    logic signed [svpd_pkg::DW-1:0] trail_reg;

    assign lead_prod  = PW'($signed(s_lead_d)) * PW'(m_reg);
    assign trail_prod = PW'($signed(s_trail_d)) * PW'(m_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lead_reg  <= svpd_pkg::DW'(lead_prod >>> 16);
            trail_reg <= svpd_pkg::DW'(trail_prod >>> 16);
        end
    end

    // ---------------- centred duties ----------------
    logic signed [svpd_pkg::DW-1:0] zero_t;
    logic signed [svpd_pkg::DW-1:0] half;
    logic signed [svpd_pkg::DW-1:0] da_next, db_next, dc_next;
    logic signed [svpd_pkg::DW-1:0] da_reg, db_reg, dc_reg;
    logic [2:0]                     sec_duty_reg;

    always_comb
    begin
        zero_t = svpd_pkg::DW'(65536) - lead_reg - trail_reg;
        half   = zero_t >>> 1;
        case (svpd_pkg::sector_t'(sec_lt))
            svpd_pkg::SEC_1:
            begin
                da_next = lead_reg + trail_reg + half;
                db_next = trail_reg + half;
                dc_next = half;
            end
            svpd_pkg::SEC_2:
            begin
                da_next = lead_reg + half;
                db_next = lead_reg + trail_reg + half;
                dc_next = half;
            end
            svpd_pkg::SEC_3:
            begin
                da_next = half;
                db_next = lead_reg + trail_reg + half;
                dc_next = trail_reg + half;
            end
            svpd_pkg::SEC_4:
            begin
                da_next = half;
                db_next = lead_reg + half;
                dc_next = lead_reg + trail_reg + half;
            end
            svpd_pkg::SEC_5:
            begin
                da_next = trail_reg + half;
                db_next = half;
                dc_next = lead_reg + trail_reg + half;
            end
            default:
            begin
                da_next = lead_reg + trail_reg + half;
                db_next = half;
                dc_next = lead_reg + half;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            da_reg       <= da_next;
            db_reg       <= db_next;
            dc_reg       <= dc_next;
            sec_duty_reg <= sec_lt;
        end
    end

    // ---------------- percent, then compare ----------------
    logic [svpd_pkg::PCT_W-1:0] pa_reg, pb_reg, pc_reg;
    logic [2:0]                 sec_pct_reg;
    logic [15:0]                cmp_a_reg, cmp_b_reg, cmp_c_reg;
    logic [2:0]                 sec_out_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pa_reg      <= svpd_pkg::duty_pct(da_reg);
            pb_reg      <= svpd_pkg::duty_pct(db_reg);
            pc_reg      <= svpd_pkg::duty_pct(dc_reg);
            sec_pct_reg <= sec_duty_reg;
            cmp_a_reg   <= svpd_pkg::pct_compare(step_reg, pa_reg);
            cmp_b_reg   <= svpd_pkg::pct_compare(step_reg, pb_reg);
            cmp_c_reg   <= svpd_pkg::pct_compare(step_reg, pc_reg);
            sec_out_reg <= sec_pct_reg;
        end
    end

    assign duty.valid     = out_valid_reg;
    assign duty.compare_a = cmp_a_reg;
    assign duty.compare_b = cmp_b_reg;
    assign duty.compare_c = cmp_c_reg;
    assign duty.sector    = sec_out_reg;

    // ---------------- checks ----------------
    a_hold_row: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("pipeline valid bits moved during a stall");

    a_take_item: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.valid && cmd.ready |=> vld_reg[0])
        else $error("accepted item not marked valid in stage 0");

    a_sector: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (sec_out_reg >= 3'd1 && sec_out_reg <= 3'd6))
        else $error("sector out of range");

    a_duty_sector: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_DUTY] |-> (sec_duty_reg != 3'd0 && sec_duty_reg != 3'd7))
        else $error("sector lost alignment with the duties");

endmodule

`default_nettype wire
